/* hdl/ipv6x_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6x_pkg
// Shared types, constants and control store of the IPv6 text expander.
// ----------------------------------------------------------------------------
package ipv6x_pkg;

  localparam int FULL_GROUPS      = 8;
  localparam int DIGITS_PER_GROUP = 4;
  localparam int MAX_GROUPS       = FULL_GROUPS + 1;

  typedef logic [6:0] char_t;
  typedef logic [DIGITS_PER_GROUP-1:0][6:0] group_t;
  typedef logic [3:0] gidx_t;
  typedef logic [2:0] slot_t;
  typedef logic [2:0] dcnt_t;
  typedef logic [2:0] upc_t;

  localparam char_t  COLON_CHAR = 7'h3A;
  localparam char_t  ZERO_CHAR  = 7'h30;
  localparam group_t ZERO_GROUP = {DIGITS_PER_GROUP{ZERO_CHAR}};
  localparam gidx_t  MAX_STORED = gidx_t'(MAX_GROUPS);
  localparam gidx_t  NO_GAP     = 4'hF;
  localparam slot_t  LAST_SLOT  = slot_t'(FULL_GROUPS - 1);
  localparam dcnt_t  DCNT_MAX   = 3'd7;

  typedef struct packed {
    char_t char_in;
    logic  end_of_address;
  } in_beat_t;

  typedef struct packed {
    char_t char_out;
    logic  last_char;
    logic  overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    OP_FETCH = 3'd0,
    OP_LOAD  = 3'd1,
    OP_DIGIT = 3'd2,
    OP_SEP   = 3'd3,
    OP_NEXT  = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] digit;
    upc_t       jmp;
  } uword_t;

  localparam upc_t UPC_FETCH = 3'd0;
  localparam upc_t UPC_LOAD  = 3'd1;

  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    w = '{op: OP_FETCH, digit: 2'd0, jmp: UPC_FETCH};
    unique case (addr)
      3'd0: w = '{op: OP_FETCH, digit: 2'd0, jmp: UPC_LOAD};
      3'd1: w = '{op: OP_LOAD,  digit: 2'd0, jmp: UPC_LOAD};
      3'd2: w = '{op: OP_DIGIT, digit: 2'd0, jmp: UPC_FETCH};
      3'd3: w = '{op: OP_DIGIT, digit: 2'd1, jmp: UPC_FETCH};
      3'd4: w = '{op: OP_DIGIT, digit: 2'd2, jmp: UPC_FETCH};
      3'd5: w = '{op: OP_DIGIT, digit: 2'd3, jmp: UPC_FETCH};
      3'd6: w = '{op: OP_SEP,   digit: 2'd0, jmp: UPC_FETCH};
      3'd7: w = '{op: OP_NEXT,  digit: 2'd0, jmp: UPC_LOAD};
      default: w = '{op: OP_FETCH, digit: 2'd0, jmp: UPC_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* hdl/ipv6x_if.sv */
// ----------------------------------------------------------------------------
// ipv6x_if
// Valid/ready channels for the character stream in and the expanded text out.
// ----------------------------------------------------------------------------
interface ipv6x_in_if;
  logic                valid;
  logic                ready;
  ipv6x_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipv6x_out_if;
  logic                 valid;
  logic                 ready;
  ipv6x_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ipv6_address_text_expander.sv */
// output: the expanded text follows the final character; an empty gap is skipped by
// the load step, and sink stalls hold the digit and separator steps
// throughput: one character per cycle while collecting; each group passes the microcode
// steps load, digit, separator and next; the last group ends at its separator step
// input is held off while the expanded text goes out, so a new address must wait
// reset: asynchronous, clears the sequencer and counters; group store has none
// ----------------------------------------------------------------------------
// ipv6_address_text_expander
// Collects a shortened IPv6 address and emits its full 39-character form.
// ----------------------------------------------------------------------------
module ipv6_address_text_expander (
  input  logic            clk_i,
  input  logic            rst_ni,
  ipv6x_in_if.sink        in_i,
  ipv6x_out_if.source     out_o
);

  ipv6x_pkg::upc_t   upc_q, upc_d;
  ipv6x_pkg::uword_t uw;

  ipv6x_pkg::group_t store_q [ipv6x_pkg::MAX_GROUPS];
  ipv6x_pkg::group_t cur_q, cur_d, cur_new;
  ipv6x_pkg::group_t grp_q, grp_d, rd_grp;
  ipv6x_pkg::gidx_t  gc_q, gc_d;
  ipv6x_pkg::gidx_t  gap_q, gap_d;
  ipv6x_pkg::gidx_t  idx_q, idx_d;
  ipv6x_pkg::gidx_t  reps_q, reps_d;
  ipv6x_pkg::dcnt_t  dc_q, dc_d;
  ipv6x_pkg::slot_t  slot_q, slot_d;
  logic              ovf_q, ovf_d;

  logic              wr_en;
  ipv6x_pkg::group_t wr_data;
  logic              in_beat, out_beat, is_colon, idx_live, last_slot;

  assign uw        = ipv6x_pkg::ucode(upc_q);
  assign in_beat   = in_i.valid && in_i.ready;
  assign out_beat  = out_o.valid && out_o.ready;
  assign is_colon  = (in_i.data.char_in == ipv6x_pkg::COLON_CHAR);
  assign idx_live  = (idx_q < gc_q);
  assign last_slot = (slot_q == ipv6x_pkg::LAST_SLOT);
  assign rd_grp    = idx_live ? store_q[idx_q] : ipv6x_pkg::ZERO_GROUP;

  always_comb begin
    cur_new = ipv6x_pkg::ZERO_GROUP;
    if (dc_q == '0) begin
      cur_new[0] = in_i.data.char_in;
    end else begin
      cur_new = ipv6x_pkg::group_t'({cur_q[ipv6x_pkg::DIGITS_PER_GROUP-2:0],
                                     in_i.data.char_in});
    end
  end

  always_comb begin
    upc_d   = upc_q;
    cur_d   = cur_q;
    grp_d   = grp_q;
    gc_d    = gc_q;
    gap_d   = gap_q;
    idx_d   = idx_q;
    reps_d  = reps_q;
    dc_d    = dc_q;
    slot_d  = slot_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_data = cur_new;
    unique case (uw.op)
      ipv6x_pkg::OP_FETCH: begin
        if (in_beat) begin
          if (is_colon) begin
            if (gc_q < ipv6x_pkg::MAX_STORED) begin
              wr_en = 1'b1;
              if (dc_q == '0) begin
                wr_data = ipv6x_pkg::ZERO_GROUP;
                gap_d   = gc_q;
              end else begin
                wr_data = cur_q;
              end
              gc_d = gc_q + 4'd1;
            end else begin
              ovf_d = 1'b1;
            end
            dc_d = '0;
          end else begin
            cur_d = cur_new;
            if (gc_q >= ipv6x_pkg::MAX_STORED) begin
              ovf_d = 1'b1;
            end
            if (dc_q != ipv6x_pkg::DCNT_MAX) begin
              dc_d = dc_q + 3'd1;
            end
            if (in_i.data.end_of_address && gc_q < ipv6x_pkg::MAX_STORED) begin
              wr_en = 1'b1;
              gc_d  = gc_q + 4'd1;
            end
          end
          if (in_i.data.end_of_address) begin
            reps_d = ipv6x_pkg::MAX_STORED - gc_d;
            idx_d  = '0;
            slot_d = '0;
            upc_d  = uw.jmp;
          end
        end
      end
      ipv6x_pkg::OP_LOAD: begin
        if (idx_live && idx_q == gap_q && reps_q == '0) begin
          idx_d = idx_q + 4'd1;
          upc_d = uw.jmp;
        end else begin
          grp_d = rd_grp;
          upc_d = upc_q + 3'd1;
        end
      end
      ipv6x_pkg::OP_DIGIT: begin
        if (out_beat) begin
          upc_d = upc_q + 3'd1;
        end
      end
      ipv6x_pkg::OP_SEP: begin
        if (last_slot) begin
          gc_d   = '0;
          dc_d   = '0;
          gap_d  = ipv6x_pkg::NO_GAP;
          ovf_d  = 1'b0;
          slot_d = '0;
          idx_d  = '0;
          upc_d  = uw.jmp;
        end else if (out_beat) begin
          upc_d = upc_q + 3'd1;
        end
      end
      ipv6x_pkg::OP_NEXT: begin
        slot_d = slot_q + 3'd1;
        if (idx_q == gap_q) begin
          reps_d = reps_q - 4'd1;
          if (reps_q == 4'd1) begin
            idx_d = idx_q + 4'd1;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
        upc_d = uw.jmp;
      end
      default: upc_d = ipv6x_pkg::UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= ipv6x_pkg::UPC_FETCH;
      gc_q   <= '0;
      gap_q  <= ipv6x_pkg::NO_GAP;
      idx_q  <= '0;
      reps_q <= '0;
      dc_q   <= '0;
      slot_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      gc_q   <= gc_d;
      gap_q  <= gap_d;
      idx_q  <= idx_d;
      reps_q <= reps_d;
      dc_q   <= dc_d;
      slot_q <= slot_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    grp_q <= grp_d;
    if (wr_en) begin
      store_q[gc_q] <= wr_data;
    end
  end

  assign in_i.ready = (uw.op == ipv6x_pkg::OP_FETCH);

  assign out_o.valid = (uw.op == ipv6x_pkg::OP_DIGIT) ||
                       (uw.op == ipv6x_pkg::OP_SEP && !last_slot);
  assign out_o.data.char_out  = (uw.op == ipv6x_pkg::OP_DIGIT) ? grp_q[~uw.digit]
                                                               : ipv6x_pkg::COLON_CHAR;
  assign out_o.data.last_char = (uw.op == ipv6x_pkg::OP_DIGIT) && (uw.digit == 2'd3) &&
                                last_slot;
  assign out_o.data.overflow  = ovf_q;

  // input and output beats never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while output valid");

  // after the final beat the sequencer passes its separator step and returns to fetch
  a_back_to_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && out_o.data.last_char) |=> ##1 in_i.ready)
    else $error("sequencer did not return to fetch");

  // address state is cleared once the expansion is done
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == ipv6x_pkg::OP_SEP && last_slot) |=>
      (gc_q == '0 && gap_q == ipv6x_pkg::NO_GAP && !ovf_q && dc_q == '0))
    else $error("address state not cleared");

  // the gap, when present, lies among the stored groups
  a_gap_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_q != ipv6x_pkg::NO_GAP) |-> (gap_q < gc_q))
    else $error("gap index beyond stored groups");

endmodule
